[src/mi3_pkg.sv]
`default_nettype none
package mi3_pkg;

  // Element format defaults
  localparam int unsigned ElemWidthDef    = 16;
  localparam int unsigned ElemFracBitsDef = 8;

  // Result format
  localparam int unsigned OutFrac  = 16;
  localparam int unsigned OutBits  = 32;
  localparam int unsigned DetBits  = 50;
  localparam int unsigned NumElems = 9;
  // Quotient bits kept before saturation (values up to 2^33 - 1)
  localparam int unsigned QuoBits  = 33;

  localparam int unsigned OutDataBits = NumElems * OutBits + DetBits;
  localparam int unsigned OutTdataW   = ((OutDataBits + 7) / 8) * 8;

  // Saturation limits as quotient magnitudes
  localparam logic [QuoBits-1:0] PosLimit = QuoBits'(33'h0_7FFF_FFFF);
  localparam logic [QuoBits-1:0] NegLimit = QuoBits'(33'h0_8000_0000);

  function automatic int unsigned max_u(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

[src/mi3_cof.sv]
`default_nettype none
// Cofactor and determinant front end: four registered stages.
module mi3_cof #(
  parameter int unsigned ELEM_WIDTH = mi3_pkg::ElemWidthDef
) (
  input  wire logic                           clk_i,
  input  wire logic [3:0]                     en_i,
  input  wire logic signed [ELEM_WIDTH-1:0]   a_i   [mi3_pkg::NumElems],
  output logic signed [2*ELEM_WIDTH:0]        cof_o [mi3_pkg::NumElems],
  output logic signed [3*ELEM_WIDTH+1:0]      det_o
);
  import mi3_pkg::*;

  localparam int unsigned EW  = ELEM_WIDTH;
  localparam int unsigned PW  = 2 * EW;
  localparam int unsigned CW  = 2 * EW + 1;
  localparam int unsigned DPW = 3 * EW + 1;
  localparam int unsigned DTW = 3 * EW + 2;

  logic signed [PW-1:0]  pa_q  [NumElems];
  logic signed [PW-1:0]  pb_q  [NumElems];
  logic signed [EW-1:0]  r0a_q [3];
  logic signed [EW-1:0]  r0b_q [3];
  logic signed [CW-1:0]  cfa_q [NumElems];
  logic signed [CW-1:0]  cfb_q [NumElems];
  logic signed [DPW-1:0] dp_q  [3];
  logic signed [DTW-1:0] det_q;

  // Stage 0: the two minor products of every cofactor
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int R1 = (j + 1) % 3;
      localparam int R2 = (j + 2) % 3;
      localparam int C1 = (i + 1) % 3;
      localparam int C2 = (i + 2) % 3;
      always_ff @(posedge clk_i) begin
        if (en_i[0]) begin
          pa_q[i*3+j] <= a_i[R1*3+C1] * a_i[R2*3+C2];
          pb_q[i*3+j] <= a_i[R1*3+C2] * a_i[R2*3+C1];
        end
        // Stage 1: cofactor differences
        if (en_i[1]) begin
          cfa_q[i*3+j] <= CW'(pa_q[i*3+j]) - CW'(pb_q[i*3+j]);
        end
        // Stages 2 and 3 carry the cofactor along
        if (en_i[2]) begin
          cfb_q[i*3+j] <= cfa_q[i*3+j];
        end
        if (en_i[3]) begin
          cof_o[i*3+j] <= cfb_q[i*3+j];
        end
      end
    end
  end

  // First row carried to the expansion, then products and sum
  for (genvar i = 0; i < 3; i++) begin : g_exp
    always_ff @(posedge clk_i) begin
      if (en_i[0]) begin
        r0a_q[i] <= a_i[i];
      end
      if (en_i[1]) begin
        r0b_q[i] <= r0a_q[i];
      end
      if (en_i[2]) begin
        dp_q[i] <= DPW'(r0b_q[i] * cfa_q[i*3]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      det_q <= DTW'(dp_q[0]) + DTW'(dp_q[1]) + DTW'(dp_q[2]);
    end
  end

  assign det_o = det_q;

endmodule
`default_nettype wire

[src/mi3_lane.sv]
`default_nettype none
// One division lane: magnitude, overflow check, one quotient bit per
// stage, then sign and saturation into the output register.
module mi3_lane #(
  parameter int unsigned ELEM_WIDTH     = mi3_pkg::ElemWidthDef,
  parameter int unsigned ELEM_FRAC_BITS = mi3_pkg::ElemFracBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic [mi3_pkg::QuoBits+2:0]       en_i,
  input  wire logic signed [2*ELEM_WIDTH:0]      cof_i,
  input  wire logic signed [3*ELEM_WIDTH+1:0]    det_i,
  output logic [mi3_pkg::OutBits-1:0]            inv_o
);
  import mi3_pkg::*;

  localparam int unsigned CW  = 2 * ELEM_WIDTH + 1;
  localparam int unsigned DTW = 3 * ELEM_WIDTH + 2;
  localparam int unsigned SH  = OutFrac + ELEM_FRAC_BITS;
  localparam int unsigned NW  = CW + SH;
  localparam int unsigned RW  = max_u(NW, DTW + QuoBits) + 1;

  logic [NW-1:0]      num_q;
  logic [DTW-1:0]     dm_q;
  logic               ngm_q;
  logic               zm_q;
  logic [CW-1:0]      cmag;
  logic [DTW-1:0]     dmag;

  logic [RW-1:0]      rem_q [QuoBits+1];
  logic [DTW-1:0]     den_q [QuoBits+1];
  logic               neg_q [QuoBits+1];
  logic               zero_q[QuoBits+1];
  logic               ovf_q [QuoBits+1];
  logic [QuoBits-1:0] qt_q  [QuoBits+1];
  logic [RW-1:0]      ovf_sh;
  logic [QuoBits-1:0] qsat;

  assign cmag = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
  assign dmag = det_i[DTW-1] ? DTW'(-det_i) : DTW'(det_i);

  // Magnitudes and result sign
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      num_q <= NW'(cmag) << SH;
      dm_q  <= dmag;
      ngm_q <= cof_i[CW-1] ^ det_i[DTW-1];
      zm_q  <= (det_i == '0);
    end
  end

  // Quotient of 2^33 or more saturates whatever the low bits are
  assign ovf_sh = RW'(dm_q) << QuoBits;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      rem_q[0]  <= RW'(num_q);
      den_q[0]  <= dm_q;
      neg_q[0]  <= ngm_q;
      zero_q[0] <= zm_q;
      ovf_q[0]  <= (RW'(num_q) >= ovf_sh);
      qt_q[0]   <= '0;
    end
  end

  // Restoring division, one quotient bit per stage, msb first
  for (genvar k = 1; k <= QuoBits; k++) begin : g_bit
    localparam int unsigned B = QuoBits - k;
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(den_q[k-1]) << B;
    assign take = (rem_q[k-1] >= dsh);
    always_ff @(posedge clk_i) begin
      if (en_i[k+1]) begin
        rem_q[k]  <= take ? (rem_q[k-1] - dsh) : rem_q[k-1];
        den_q[k]  <= den_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        qt_q[k]   <= qt_q[k-1] | (QuoBits'(take) << B);
      end
    end
  end

  // Saturate the magnitude, then apply the sign
  always_comb begin
    if (neg_q[QuoBits]) begin
      qsat = (ovf_q[QuoBits] || qt_q[QuoBits] > NegLimit) ? NegLimit : qt_q[QuoBits];
    end else begin
      qsat = (ovf_q[QuoBits] || qt_q[QuoBits] > PosLimit) ? PosLimit : qt_q[QuoBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[QuoBits+2]) begin
      if (zero_q[QuoBits]) begin
        inv_o <= '0;
      end else if (neg_q[QuoBits]) begin
        inv_o <= OutBits'(-qsat);
      end else begin
        inv_o <= OutBits'(qsat);
      end
    end
  end

endmodule
`default_nettype wire

[src/real_matrix3_inverse.sv]
`default_nettype none
// 3x3 real matrix inverse by the adjugate.
// Input channel s_axis: one item is a whole matrix, nine signed elements
// a00..a22 in row-major order with ELEM_FRAC_BITS fraction bits.
// Output channel m_axis: one item per input item, in order: nine inverse
// elements with 16 fraction bits, saturated to 32 bits and truncated
// toward zero, the exact determinant (3*ELEM_FRAC_BITS fraction bits)
// and, in tuser, a singular flag; a singular matrix gives all zeros.
// From accept to tvalid an item passes four stages of cofactor
// and determinant products, then nine division lanes of 36 stages each
// (magnitude, overflow check, 33 quotient-bit stages, saturation).
// Throughput is one matrix per cycle while m_axis is not stalled; the
// restoring dividers are fully pipelined. Every stage holds its item
// while the stage ahead is full, so empty stages still fill while m_axis
// is stalled and s_axis_tready drops only once the whole pipeline is full.
// Reset clears all stage valid bits; the output goes idle at once.
module real_matrix3_inverse #(
  parameter int unsigned ELEM_WIDTH     = mi3_pkg::ElemWidthDef,
  parameter int unsigned ELEM_FRAC_BITS = mi3_pkg::ElemFracBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22 from bit 0 up
  input  wire logic [((9*ELEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // inv00 .. inv22, det_value from bit 0 up, zero padded
  output logic [mi3_pkg::OutTdataW-1:0]         m_axis_tdata,
  // singular
  output logic                                  m_axis_tuser
);
  import mi3_pkg::*;

  localparam int unsigned CW  = 2 * ELEM_WIDTH + 1;
  localparam int unsigned DTW = 3 * ELEM_WIDTH + 2;
  localparam int unsigned FST = 4;
  localparam int unsigned LST = QuoBits + 3;
  localparam int unsigned NS  = FST + LST;

  logic [NS-1:0]                 v_q;
  logic [NS-1:0]                 v_d;
  logic [NS-1:0]                 en;
  logic signed [ELEM_WIDTH-1:0]  a      [NumElems];
  logic signed [CW-1:0]          cof    [NumElems];
  logic signed [DTW-1:0]         det;
  logic [OutBits-1:0]            inv    [NumElems];
  logic signed [DTW-1:0]         detc_q [LST];
  logic signed [DetBits-1:0]     det_out;

  // Stage enables: a stage loads when empty or when it moves on
  always_comb begin
    en[NS-1] = !v_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? s_axis_tvalid : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NS-1];

  for (genvar e = 0; e < NumElems; e++) begin : g_unpack
    assign a[e] = s_axis_tdata[e*ELEM_WIDTH +: ELEM_WIDTH];
  end

  mi3_cof #(
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_cof (
    .clk_i,
    .en_i (en[FST-1:0]),
    .a_i  (a),
    .cof_o(cof),
    .det_o(det)
  );

  for (genvar e = 0; e < NumElems; e++) begin : g_lane
    mi3_lane #(
      .ELEM_WIDTH    (ELEM_WIDTH),
      .ELEM_FRAC_BITS(ELEM_FRAC_BITS)
    ) u_lane (
      .clk_i,
      .en_i (en[NS-1:FST]),
      .cof_i(cof[e]),
      .det_i(det),
      .inv_o(inv[e])
    );
  end

  // Determinant travels beside the lanes
  always_ff @(posedge clk_i) begin
    if (en[FST]) begin
      detc_q[0] <= det;
    end
  end
  for (genvar k = 1; k < LST; k++) begin : g_detc
    always_ff @(posedge clk_i) begin
      if (en[FST+k]) begin
        detc_q[k] <= detc_q[k-1];
      end
    end
  end

  // Merge lane results into the output item
  assign det_out = DetBits'(detc_q[LST-1]);

  always_comb begin
    m_axis_tdata = '0;
    for (int e = 0; e < NumElems; e++) begin
      m_axis_tdata[e*OutBits +: OutBits] = inv[e];
    end
    m_axis_tdata[NumElems*OutBits +: DetBits] = det_out;
  end

  assign m_axis_tuser = (detc_q[LST-1] == '0);

endmodule
`default_nettype wire

[src/mi3_chk.sv]
`default_nettype none
// Port-level checks for the inverse block.
module mi3_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [mi3_pkg::OutTdataW-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser
);
  import mi3_pkg::*;

  localparam int unsigned DetLo = NumElems * OutBits;

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Singular result is all zero
  a_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("singular result not zero");

  // Regular result has a nonzero determinant
  a_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[DetLo +: DetBits] != '0)
    else $error("zero determinant without singular flag");

  // An empty output stage frees the whole pipeline
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with output empty");

endmodule

bind real_matrix3_inverse mi3_chk u_mi3_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire

[dv/real_matrix3_inverse_check.sv]
`timescale 1ns / 1ps
module real_matrix3_inverse_check (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [143:0] s_data_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [mi3_pkg::OutTdataW-1:0] m_data_i,
  input  logic         m_user_i,
  output int           errors_o,
  output int           pending_o
);
  import mi3_pkg::*;

  typedef struct packed {
    logic         singular;
    logic [49:0]  det;
    logic [287:0] inv;
  } inverse_t;

  inverse_t inverse_q[$];

  assign pending_o = inverse_q.size();

  // Signed quotient with 16 fraction bits, truncated toward zero, saturated
  function automatic logic [31:0] scaled_quotient(longint cof, longint det);
    logic neg;
    longint unsigned num, den, q;
    neg = (cof < 0) != (det < 0);
    num = longint'(cof < 0 ? -cof : cof) << (OutFrac + 8);
    den = det < 0 ? -det : det;
    q = num / den;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return 32'(q);
  endfunction

  // Adjugate inverse of one matrix
  function automatic inverse_t predict_inverse(logic [143:0] data);
    longint m[3][3];
    longint adj[3][3];
    longint det;
    inverse_t r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = longint'($signed(data[(i*3+j)*16 +: 16]));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        adj[i][j] = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3]
                  - m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
    det = 0;
    for (int i = 0; i < 3; i++) det += m[0][i] * adj[i][0];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r.inv[(i*3+j)*32 +: 32] = scaled_quotient(adj[i][j], det);
    r.det = 50'(det);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    inverse_t want, got;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (s_valid_i && s_ready_i) inverse_q.push_back(predict_inverse(s_data_i));
      if (m_valid_i && m_ready_i) begin
        got.inv = m_data_i[287:0];
        got.det = m_data_i[337:288];
        got.singular = m_user_i;
        if (inverse_q.size() == 0) begin
          errors_o <= errors_o + 1;
          if (errors_o < 10) $display("unexpected result item %h", got);
        end else begin
          want = inverse_q.pop_front();
          if (want != got) begin
            errors_o <= errors_o + 1;
            if (errors_o < 10) begin
              for (int k = 0; k < 9; k++)
                if (want.inv[k*32 +: 32] != got.inv[k*32 +: 32])
                  $display("inv%0d%0d: expected %h got %h", k / 3, k % 3,
                           want.inv[k*32 +: 32], got.inv[k*32 +: 32]);
              if (want.det != got.det)
                $display("det: expected %h got %h", want.det, got.det);
              if (want.singular != got.singular)
                $display("singular: expected %b got %b", want.singular, got.singular);
            end
          end
        end
      end
    end
  end
endmodule

[dv/real_matrix3_inverse_test.sv]
`timescale 1ns / 1ps
module real_matrix3_inverse_test;
  import mi3_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  int errors, pending;
  int idle_pct = 18;
  bit hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  real_matrix3_inverse u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  real_matrix3_inverse_check u_check (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_user_i(m_axis_tuser),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver: random stalls, plus one long hold-off
  always @(posedge clk_i)
    m_axis_tready <= !hold_off && ($urandom_range(99) >= idle_pct);

  initial begin
    wait (rst_ni);
    repeat (300) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // One random element: mostly small, sometimes full range
  function automatic logic [15:0] rand_elem();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed(8'($urandom)));
      default: return 16'($signed($urandom_range(1023)) - 512);
    endcase
  endfunction

  function automatic logic [143:0] rand_matrix();
    logic [143:0] d;
    for (int k = 0; k < 9; k++) d[k*16 +: 16] = rand_elem();
    // Occasionally force a singular matrix: row 2 copies row 0
    if ($urandom_range(15) == 0) d[96 +: 48] = d[0 +: 48];
    return d;
  endfunction

  task automatic send_matrix(logic [143:0] d);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_diag(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    send_matrix({c, 32'h0, 16'h0, b, 16'h0, 32'h0, a});
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: identity, scaled, extremes, singular, saturation
    send_diag(16'h0100, 16'h0100, 16'h0100);
    send_diag(16'hFF00, 16'h0200, 16'h0080);
    send_diag(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_diag(16'h8000, 16'h8000, 16'h8000);
    send_diag(16'h8000, 16'h7FFF, 16'h0001);
    send_diag(16'h0001, 16'h0001, 16'h0001);
    send_diag(16'hFFFF, 16'h0001, 16'h0001);
    send_diag(16'h0001, 16'h7FFF, 16'h8000);
    send_matrix('0);
    send_matrix({9{16'h7FFF}});
    send_matrix({9{16'h8000}});
    send_matrix({9{16'hFFFF}});
    send_matrix({16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
                 16'h0000, 16'h0100, 16'h0000});
    send_matrix({16'h8000, 16'h7FFF, 16'h0001, 16'h0002, 16'h8000, 16'h7FFF,
                 16'h7FFF, 16'h0003, 16'h8000});
    // Pause until every result has come back
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);
    for (int n = 0; n < 900; n++) begin
      idle_pct = (n >= 400 && n < 550) ? 0 : 18;
      send_matrix(rand_matrix());
    end
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end
endmodule
